/* rtl/core/smf_pkg.sv */
// ----------------------------------------------------------------------------
// smf_pkg
// Beat types and field widths shared by the sliding median filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

	localparam int TIME_W  = 31;
	localparam int LEVEL_W = 32;

	typedef struct packed {
		logic                      restart;
		logic [TIME_W-1:0]         sample_time;
		logic signed [LEVEL_W-1:0] sample_level;
	} sample_t;

	typedef struct packed {
		logic [TIME_W-1:0]         center_time;
		logic signed [LEVEL_W-1:0] median_level;
	} result_t;

endpackage

/* rtl/core/smf_cell.sv */
// ----------------------------------------------------------------------------
// smf_cell
// One window slot: holds a sample and its rank among the valid slots, and
// takes over its younger neighbor's sample with the rank updated for the
// sample that leaves and the one that arrives.
// ----------------------------------------------------------------------------
module smf_cell #(
	parameter int RANK_W = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift,
	input  logic signed [smf_pkg::LEVEL_W-1:0] in_level,
	input  logic [smf_pkg::TIME_W-1:0]         in_stamp,
	input  logic                              in_valid,
	input  logic [RANK_W-1:0]                 in_rank,
	input  logic signed [smf_pkg::LEVEL_W-1:0] leave_level,
	input  logic                              leave_valid,
	input  logic signed [smf_pkg::LEVEL_W-1:0] new_level,
	output logic signed [smf_pkg::LEVEL_W-1:0] level,
	output logic [smf_pkg::TIME_W-1:0]         stamp,
	output logic                              valid,
	output logic [RANK_W-1:0]                 rank,
	output logic                              le_new
);

	logic signed [smf_pkg::LEVEL_W-1:0] level_q;
	logic [smf_pkg::TIME_W-1:0]         stamp_q;
	logic                              valid_q;
	logic [RANK_W-1:0]                 rank_q;
	logic [RANK_W-1:0]                 rank_next;

	// ties ordered by age: an older equal sample sits below, a newer one above
	assign rank_next = in_rank
		+ RANK_W'(new_level < in_level)
		- RANK_W'(leave_valid && (leave_level <= in_level));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			level_q <= in_level;
			stamp_q <= in_stamp;
			rank_q  <= rank_next;
		end
	end

	assign level  = level_q;
	assign stamp  = stamp_q;
	assign valid  = valid_q;
	assign rank   = rank_q;
	assign le_new = valid_q && (level_q <= new_level);

endmodule

/* rtl/core/sliding_median_filter.sv */
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median over the last WINDOW timestamped samples.
// ----------------------------------------------------------------------------
// Input beats (sample) carry a restart flag, a timestamp and a signed Q16.16
// level; output beats (result) carry the median level of the window and the
// timestamp of its center sample. Both channels use valid/stall.
// The window is a row of WINDOW cells, each keeping its sample's rank among
// the valid cells; every accepted beat shifts the row by one and updates all
// ranks in the same cycle, so one sample is taken every clock while sample_stall is low.
// Once WINDOW samples of a series are held, every sample yields one result
// beat, registered in the cell row and then in the output register. The
// first WINDOW-1 samples after reset or a restart yield nothing. A restart
// drops the window before its own sample goes in.
// Reset empties the window and the output register.
// A stalled result holds; the row keeps one finished window pending behind
// it, and sample_stall rises only when both are occupied and result_stall
// is high.
// ----------------------------------------------------------------------------
module sliding_median_filter #(
	parameter int WINDOW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  smf_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output smf_pkg::result_t result
);

	localparam int RANK_W = $clog2(WINDOW + 1);
	localparam int MID    = WINDOW / 2;

	logic signed [smf_pkg::LEVEL_W-1:0] lvl   [WINDOW];
	logic [smf_pkg::TIME_W-1:0]         stamp [WINDOW];
	logic [RANK_W-1:0]                  rank  [WINDOW];
	logic [WINDOW-1:0]                  valid;
	logic [WINDOW-1:0]                  le_new;
	logic [WINDOW-1:0]                  vin;
	logic [WINDOW-1:0]                  sel;
	logic [RANK_W-1:0]                  new_rank;
	logic                               leave_valid;
	logic                               accept;
	logic                               load_out;
	logic                               pend_q;
	logic                               res_valid_q;
	smf_pkg::result_t                   res_q;
	logic signed [smf_pkg::LEVEL_W-1:0] med;

	assign load_out     = pend_q && (!res_valid_q || !result_stall);
	assign sample_stall = pend_q && !load_out;
	assign accept       = sample_valid && !sample_stall;
	assign leave_valid  = valid[0] && !sample.restart;

	// rank of the arriving sample among all held ones; the leaving one is
	// taken back out inside the last cell
	always_comb begin
		new_rank = '0;
		if (!sample.restart) begin
			for (int j = 0; j < WINDOW; j++) begin
				new_rank = new_rank + RANK_W'(le_new[j]);
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < WINDOW; g++) begin : g_cell
			if (g == WINDOW - 1) begin : g_head
				assign vin[g] = 1'b1;
				smf_cell #(.RANK_W(RANK_W)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (accept),
					.in_level   (sample.sample_level),
					.in_stamp   (sample.sample_time),
					.in_valid   (vin[g]),
					.in_rank    (new_rank),
					.leave_level(lvl[0]),
					.leave_valid(leave_valid),
					.new_level  (sample.sample_level),
					.level      (lvl[g]),
					.stamp      (stamp[g]),
					.valid      (valid[g]),
					.rank       (rank[g]),
					.le_new     (le_new[g])
				);
			end else begin : g_body
				assign vin[g] = valid[g+1] && !sample.restart;
				smf_cell #(.RANK_W(RANK_W)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift      (accept),
					.in_level   (lvl[g+1]),
					.in_stamp   (stamp[g+1]),
					.in_valid   (vin[g]),
					.in_rank    (rank[g+1]),
					.leave_level(lvl[0]),
					.leave_valid(leave_valid),
					.new_level  (sample.sample_level),
					.level      (lvl[g]),
					.stamp      (stamp[g]),
					.valid      (valid[g]),
					.rank       (rank[g]),
					.le_new     (le_new[g])
				);
			end
		end
	endgenerate

	always_comb begin
		med = '0;
		for (int j = 0; j < WINDOW; j++) begin
			sel[j] = valid[j] && (rank[j] == RANK_W'(MID));
			if (sel[j]) begin
				med = med | lvl[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= &vin;
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.center_time  <= stamp[MID];
			res_q.median_level <= med;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a full window has exactly one cell at the middle rank
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $onehot(sel))
		else $error("median rank not unique in a full window");

	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (&valid))
		else $error("window result pending with empty cells");

	a_restart_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.restart) |=> (!pend_q && ($countones(valid) == 1)))
		else $error("restart left old samples in the window");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && !load_out) |=> pend_q)
		else $error("pending window lost before reaching the output");

endmodule
